// ===== hdl/swhsr_pkg.sv =====
// shared types, codes and defaults for the humidity sensor reader
package swhsr_pkg;

	localparam int TICK_COUNTER_BITS_DEF = 16;
	localparam int FRAME_BITS            = 40;
	localparam int BITS_CNT_W            = 6;
	localparam int CFG_DATA_W            = 16;
	localparam int CFG_INDEX_W           = 3;

	localparam logic [15:0] START_LOW_RST = 16'd1000;
	localparam logic [7:0]  RELEASE_RST   = 8'd30;
	localparam logic [7:0]  RESP_TO_RST   = 8'd100;
	localparam logic [7:0]  BIT_LOW_RST   = 8'd70;
	localparam logic [7:0]  BIT_HIGH_RST  = 8'd90;
	localparam logic [7:0]  ONE_THR_RST   = 8'd40;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_LOW = 3'd0,
		REG_RELEASE   = 3'd1,
		REG_RESP_TO   = 3'd2,
		REG_BIT_LOW   = 3'd3,
		REG_BIT_HIGH  = 3'd4,
		REG_ONE_THR   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START_LOW = 3'd1,
		PH_RELEASE   = 3'd2,
		PH_RESP_A    = 3'd3,
		PH_RESP_B    = 3'd4,
		PH_RESP_C    = 3'd5,
		PH_BIT_LOW   = 3'd6,
		PH_BIT_HIGH  = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_RESP_A_TO   = 3'd1,
		ST_RESP_B_TO   = 3'd2,
		ST_RESP_C_TO   = 3'd3,
		ST_BIT_LOW_TO  = 3'd4,
		ST_BIT_HIGH_TO = 3'd5,
		ST_CHECKSUM    = 3'd6
	} status_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  response_timeout;
		logic [7:0]  bit_low_timeout;
		logic [7:0]  bit_high_timeout;
		logic [7:0]  one_threshold;
	} cfg_t;

	typedef struct packed {
		logic               drive_enable;
		logic               drive_level;
		logic               busy;
		logic               done;
		status_t            status;
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} result_t;

endpackage

// ===== hdl/swhsr_ifs.sv =====
// handshake channels for line samples and readings
interface swhsr_sample_if;
	logic valid;
	logic ready;
	logic action;
	logic line_level;

	modport source (output valid, output action, output line_level, input ready);
	modport sink   (input valid, input action, input line_level, output ready);
endinterface

interface swhsr_reading_if;
	logic               valid;
	logic               ready;
	logic               drive_enable;
	logic               drive_level;
	logic               busy_res;
	logic               done_res;
	logic [2:0]         status;
	logic [15:0]        humidity_tenths;
	logic signed [15:0] temperature_tenths;

	modport source (output valid, output drive_enable, output drive_level, output busy_res,
		output done_res, output status, output humidity_tenths, output temperature_tenths,
		input ready);
	modport sink (input valid, input drive_enable, input drive_level, input busy_res,
		input done_res, input status, input humidity_tenths, input temperature_tenths,
		output ready);
endinterface

// ===== hdl/swhsr_cfg.sv =====
// configuration register bank
module swhsr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [swhsr_pkg::CFG_INDEX_W-1:0]   index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]    wdata,
	output swhsr_pkg::cfg_t                     cfg
);
	import swhsr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks  <= START_LOW_RST;
			cfg_q.release_ticks    <= RELEASE_RST;
			cfg_q.response_timeout <= RESP_TO_RST;
			cfg_q.bit_low_timeout  <= BIT_LOW_RST;
			cfg_q.bit_high_timeout <= BIT_HIGH_RST;
			cfg_q.one_threshold    <= ONE_THR_RST;
		end else if (wr_en) begin
			case (index)
				REG_START_LOW: cfg_q.start_low_ticks  <= wdata;
				REG_RELEASE:   cfg_q.release_ticks    <= wdata[7:0];
				REG_RESP_TO:   cfg_q.response_timeout <= wdata[7:0];
				REG_BIT_LOW:   cfg_q.bit_low_timeout  <= wdata[7:0];
				REG_BIT_HIGH:  cfg_q.bit_high_timeout <= wdata[7:0];
				REG_ONE_THR:   cfg_q.one_threshold    <= wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/swhsr_core.sv =====
// phase sequencer, pulse timing, bit capture and frame decode
module swhsr_core #(
	parameter int TICK_COUNTER_BITS = swhsr_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swhsr_pkg::cfg_t    cfg,
	input  logic               go,
	input  logic               action,
	input  logic               line_level,
	output swhsr_pkg::result_t res
);
	import swhsr_pkg::*;

	localparam int CW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
	localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = '1;

	phase_t                         phase_q, phase_d;
	logic [TICK_COUNTER_BITS-1:0]   tick_q, tick_d;
	logic [BITS_CNT_W-1:0]          bits_q, bits_d;
	logic [FRAME_BITS-1:0]          frame_q, frame_d;

	logic [TICK_COUNTER_BITS-1:0]   cnt_inc;
	logic [CW-1:0]                  cnt_x;
	logic                           sat;
	logic                           resp_to, low_to, high_to;
	logic                           drv_low_done, drv_rel_done;
	logic                           bit_val;
	logic [BITS_CNT_W-1:0]          bits_inc;
	logic [FRAME_BITS-1:0]          frame_new;
	logic [7:0]                     sum8;
	logic [15:0]                    raw_temp;
	logic                           finish;
	status_t                        end_status;
	logic                           frame_ok;

	// saturating count and limit checks on the incremented count
	always_comb begin
		cnt_inc      = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
		cnt_x        = CW'(cnt_inc);
		sat          = (cnt_inc == TICK_MAX);
		resp_to      = (cnt_x > CW'(cfg.response_timeout)) || sat;
		low_to       = (cnt_x > CW'(cfg.bit_low_timeout)) || sat;
		high_to      = (cnt_x > CW'(cfg.bit_high_timeout)) || sat;
		drv_low_done = (cnt_x >= CW'(cfg.start_low_ticks)) || sat;
		drv_rel_done = (cnt_x >= CW'(cfg.release_ticks)) || sat;
		bit_val      = CW'(tick_q) > CW'(cfg.one_threshold);
		bits_inc     = bits_q + 1'b1;
		frame_new    = {frame_q[FRAME_BITS-2:0], bit_val};
		sum8         = frame_new[39:32] + frame_new[31:24] + frame_new[23:16]
			+ frame_new[15:8];
		raw_temp     = frame_new[23:8];
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bits_d     = bits_q;
		frame_d    = frame_q;
		finish     = 1'b0;
		end_status = ST_OK;
		frame_ok   = 1'b0;
		if (action) begin
			if (phase_q == PH_IDLE) begin
				phase_d = PH_START_LOW;
				tick_d  = '0;
				bits_d  = '0;
				frame_d = '0;
			end
		end else begin
			case (phase_q)
				PH_START_LOW: begin
					tick_d = cnt_inc;
					if (drv_low_done) begin
						phase_d = PH_RELEASE;
						tick_d  = '0;
					end
				end
				PH_RELEASE: begin
					tick_d = cnt_inc;
					if (drv_rel_done) begin
						phase_d = PH_RESP_A;
						tick_d  = '0;
					end
				end
				PH_RESP_A: begin
					if (!line_level) begin
						phase_d = PH_RESP_B;
						tick_d  = '0;
					end else begin
						tick_d = cnt_inc;
						if (resp_to) begin
							finish     = 1'b1;
							end_status = ST_RESP_A_TO;
						end
					end
				end
				PH_RESP_B: begin
					if (line_level) begin
						phase_d = PH_RESP_C;
						tick_d  = '0;
					end else begin
						tick_d = cnt_inc;
						if (resp_to) begin
							finish     = 1'b1;
							end_status = ST_RESP_B_TO;
						end
					end
				end
				PH_RESP_C: begin
					if (!line_level) begin
						phase_d = PH_BIT_LOW;
						tick_d  = '0;
					end else begin
						tick_d = cnt_inc;
						if (resp_to) begin
							finish     = 1'b1;
							end_status = ST_RESP_C_TO;
						end
					end
				end
				PH_BIT_LOW: begin
					if (line_level) begin
						phase_d = PH_BIT_HIGH;
						tick_d  = TICK_COUNTER_BITS'(1);
					end else begin
						tick_d = cnt_inc;
						if (low_to) begin
							finish     = 1'b1;
							end_status = ST_BIT_LOW_TO;
						end
					end
				end
				PH_BIT_HIGH: begin
					if (!line_level) begin
						frame_d = frame_new;
						bits_d  = bits_inc;
						tick_d  = '0;
						if (bits_inc >= BITS_CNT_W'(FRAME_BITS)) begin
							finish = 1'b1;
							if (sum8 != frame_new[7:0]) begin
								end_status = ST_CHECKSUM;
							end else begin
								frame_ok = 1'b1;
							end
						end else begin
							phase_d = PH_BIT_LOW;
						end
					end else begin
						tick_d = cnt_inc;
						if (high_to) begin
							finish     = 1'b1;
							end_status = ST_BIT_HIGH_TO;
						end
					end
				end
				default: begin
				end
			endcase
			if (finish) begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		end
	end

	// result seen after this item
	always_comb begin
		res.drive_enable       = (phase_d == PH_START_LOW) || (phase_d == PH_RELEASE);
		res.drive_level        = (phase_d == PH_RELEASE);
		res.busy               = (phase_d != PH_IDLE);
		res.done               = finish;
		res.status             = end_status;
		res.humidity_tenths    = '0;
		res.temperature_tenths = '0;
		if (frame_ok) begin
			res.humidity_tenths = frame_new[39:24];
			// sign-magnitude to two's complement, negative zero folds to zero
			if (raw_temp[15]) begin
				res.temperature_tenths = 16'(16'd0 - {1'b0, raw_temp[14:0]});
			end else begin
				res.temperature_tenths = raw_temp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bits_q  <= '0;
			frame_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bits_q  <= bits_d;
			frame_q <= frame_d;
		end
	end

`ifndef ASSERT_OFF
	a_start_busy_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(go && action && phase_q != PH_IDLE) |=> (phase_q == $past(phase_q)))
		else $error("start while busy changed the phase");
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q <= BITS_CNT_W'(FRAME_BITS)))
		else $error("bit count ran past the frame length");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.done) |=> (phase_q == PH_IDLE && tick_q == '0))
		else $error("finished reading did not return to idle");
`endif

endmodule

// ===== hdl/single_wire_humidity_sensor_reader_top.sv =====
// path: an accepted item is held in the input register, and its reading then in the output register
// throughput: one item per cycle; the input register keeps taking items while
// a reading waits in the output register, stalling only when both are full
// each item is decoded in one pass between the input and output registers
// reset clears the phase, counters, frame and valid flags and loads register defaults
module single_wire_humidity_sensor_reader_top #(
	parameter int TICK_COUNTER_BITS = swhsr_pkg::TICK_COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	swhsr_sample_if.sink                        sample,
	swhsr_reading_if.source                     reading,
	input  logic                                cfg_wr_en,
	input  logic [swhsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import swhsr_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    s1_valid_q;
	logic    action_s1;
	logic    line_s1;
	logic    out_valid_q;
	logic    advance;
	logic    go;
	logic    take;

	assign advance      = !out_valid_q || reading.ready;
	assign go           = s1_valid_q && advance;
	assign sample.ready = !s1_valid_q || advance;
	assign take         = sample.valid && sample.ready;

	swhsr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	swhsr_core #(
		.TICK_COUNTER_BITS (TICK_COUNTER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.go         (go),
		.action     (action_s1),
		.line_level (line_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1 <= sample.action;
			line_s1   <= sample.line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (reading.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res;
		end
	end

	assign reading.valid              = out_valid_q;
	assign reading.drive_enable       = res_q.drive_enable;
	assign reading.drive_level        = res_q.drive_level;
	assign reading.busy_res           = res_q.busy;
	assign reading.done_res           = res_q.done;
	assign reading.status             = res_q.status;
	assign reading.humidity_tenths    = res_q.humidity_tenths;
	assign reading.temperature_tenths = res_q.temperature_tenths;

`ifndef ASSERT_OFF
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> s1_valid_q)
		else $error("accepted item missing from input register");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> (s1_valid_q && $stable(action_s1) && $stable(line_s1)))
		else $error("stalled item in input register was lost or changed");
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("reading appeared without an item behind it");
`endif

endmodule
